>>> src/cggl_pkg.sv
`default_nettype none

package cggl_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int LEVEL_W   = 19;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 19;

    // Accumulators
    localparam int MAX_BLOCK_SAMPLES = 4096;
    localparam int COUNT_W = 13;
    localparam int SUM_W   = 52;
    localparam int SQ_W    = 2 * LEVEL_W;          // squared magnitude

    // Mean of squares stays below 2**SQ_W, so its quotient has SQ_W bits.
    localparam int DIV_STEPS  = SQ_W;
    localparam int SQRT_STEPS = LEVEL_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int DREM_W     = COUNT_W;
    localparam int SREM_W     = LEVEL_W + 2;

    localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(MAX_BLOCK_SAMPLES - 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH_MODE = 2'd0,
        CFG_VOLUME     = 2'd1,
        CFG_GATE       = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       block_last;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       levels_valid;
        logic [LEVEL_W-1:0]         peak_level;
        logic [LEVEL_W-1:0]         rms_level;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_SQUARE,
        S_ACCUM,
        S_DIV_INIT,
        S_DIV,
        S_SQRT_INIT,
        S_SQRT,
        S_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scale;
        logic square;
        logic accum;
        logic div_init;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic blk_end;
    } t_stat;

endpackage

`default_nettype wire

>>> src/cggl_ctrl.sv
`default_nettype none

module cggl_ctrl
    import cggl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic r_out_valid, n_out_valid;
    logic w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_SCALE;
            S_SCALE:     n_state = S_SQUARE;
            S_SQUARE:    n_state = S_ACCUM;
            S_ACCUM:     n_state = i_stat.blk_end ? S_DIV_INIT : S_OUT;
            S_DIV_INIT:  n_state = S_DIV;
            S_DIV:       if (r_step == '0) n_state = S_SQRT_INIT;
            S_SQRT_INIT: n_state = S_SQRT;
            S_SQRT:      if (r_step == '0) n_state = S_OUT;
            S_OUT:       if (w_slot_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_step     = r_step;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SCALE:  o_cmd.scale  = 1'b1;
            S_SQUARE: o_cmd.square = 1'b1;
            S_ACCUM:  o_cmd.accum  = 1'b1;
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_step = STEP_W'(DIV_STEPS - 1);
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step - 1'b1;
            end
            S_SQRT_INIT: begin
                o_cmd.sqrt_init = 1'b1;
                n_step = STEP_W'(SQRT_STEPS - 1);
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step = r_step - 1'b1;
            end
            S_OUT:   o_cmd.out_load = w_slot_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> src/cggl_dp.sv
`default_nettype none

module cggl_dp
    import cggl_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire t_in_word             i_in_word,
    input  wire t_cmd                 i_cmd,
    output t_stat                     o_stat,
    output t_out_word                 o_out_word
);

    // configuration
    logic                r_mode;
    logic [GAIN_W-1:0]   r_gain;
    logic [LEVEL_W-1:0]  r_gate;

    // per-word registers
    logic signed [32:0]         r_prod;
    logic                       r_last;
    logic                       r_end;
    logic [LEVEL_W-1:0]         r_mag;
    logic signed [SAMPLE_W-1:0] r_smp;
    logic [SQ_W-1:0]            r_sq;

    // accumulators
    logic [LEVEL_W-1:0] r_peak;
    logic [SUM_W-1:0]   r_sum;
    logic [COUNT_W-1:0] r_count;

    // divide / root registers; r_dq is shared by both
    logic [SQ_W-1:0]    r_dq;
    logic [DREM_W-1:0]  r_drem;
    logic [SREM_W-1:0]  r_srem;
    logic [LEVEL_W-1:0] r_root;

    t_out_word r_out;

    // front end
    logic signed [SAMPLE_W-1:0] w_q15;
    logic signed [32:0]         w_prod_b;
    logic signed [20:0]         w_scaled;
    logic signed [20:0]         w_abs;
    logic [LEVEL_W-1:0]         w_mag;
    logic signed [20:0]         w_s8b;
    logic signed [12:0]         w_s8q;
    logic signed [SAMPLE_W-1:0] w_s16;
    logic signed [7:0]          w_s8;
    logic signed [SAMPLE_W-1:0] w_smp;

    // iteration
    logic [DREM_W:0]    w_dt;
    logic               w_dge;
    logic [SREM_W+1:0]  w_st;
    logic [SREM_W+1:0]  w_strial;
    logic               w_sge;

    assign w_q15 = r_mode ? i_in_word.sample_in
                          : {i_in_word.sample_in[7], i_in_word.sample_in[7:0], 7'b0};

    // truncate toward zero: bias negatives before the arithmetic shift
    assign w_prod_b = r_prod + (r_prod[32] ? 33'sd4095 : 33'sd0);
    assign w_scaled = w_prod_b[32:12];
    assign w_abs    = w_scaled[20] ? -w_scaled : w_scaled;
    assign w_mag    = w_abs[LEVEL_W-1:0];

    always_comb begin
        priority if (w_scaled > 21'sd32767) begin
            w_s16 = 16'sd32767;
        end else if (w_scaled < -21'sd32768) begin
            w_s16 = -16'sd32768;
        end else begin
            w_s16 = w_scaled[15:0];
        end
    end

    assign w_s8b = w_scaled + (w_scaled[20] ? 21'sd255 : 21'sd0);
    assign w_s8q = w_s8b[20:8];

    always_comb begin
        priority if (w_s8q > 13'sd127) begin
            w_s8 = 8'sd127;
        end else if (w_s8q < -13'sd128) begin
            w_s8 = -8'sd128;
        end else begin
            w_s8 = w_s8q[7:0];
        end
    end

    always_comb begin
        if (w_mag > r_gate) begin
            w_smp = r_mode ? w_s16 : SAMPLE_W'(w_s8);
        end else begin
            w_smp = '0;
        end
    end

    // restoring divide, one quotient bit per step
    assign w_dt  = {r_drem, r_dq[SQ_W-1]};
    assign w_dge = w_dt >= {1'b0, r_count};

    // root, two radicand bits per step
    assign w_st     = {r_srem, r_dq[SQ_W-1:SQ_W-2]};
    assign w_strial = (SREM_W+2)'({r_root, 2'b01});
    assign w_sge    = w_st >= w_strial;

    assign o_stat.blk_end = r_last || (r_count == LAST_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
            r_gain <= GAIN_W'(4096);
            r_gate <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH_MODE: r_mode <= i_cfg_data[0];
                CFG_VOLUME:     r_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_GATE:       r_gate <= i_cfg_data[LEVEL_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= '0;
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_cmd.accum) begin
            r_sum   <= r_sum + SUM_W'(r_sq);
            r_count <= r_count + 1'b1;
            if (r_mag > r_peak) r_peak <= r_mag;
        end else if (i_cmd.out_load && r_end) begin
            r_peak  <= '0;
            r_sum   <= '0;
            r_count <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prod <= w_q15 * $signed({1'b0, r_gain});
            r_last <= i_in_word.block_last;
        end
        if (i_cmd.scale) begin
            r_mag <= w_mag;
            r_smp <= w_smp;
        end
        if (i_cmd.square) begin
            r_sq <= r_mag * r_mag;
        end
        if (i_cmd.accum) begin
            r_end <= o_stat.blk_end;
        end
        priority if (i_cmd.div_init) begin
            // high part of the sum is already below the count
            r_drem <= r_sum[SUM_W-1-1:SQ_W];
            r_dq   <= r_sum[SQ_W-1:0];
        end else if (i_cmd.div_step) begin
            r_drem <= w_dge ? DREM_W'(w_dt - {1'b0, r_count}) : w_dt[DREM_W-1:0];
            r_dq   <= {r_dq[SQ_W-2:0], w_dge};
        end else if (i_cmd.sqrt_init) begin
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_srem <= w_sge ? SREM_W'(w_st - w_strial) : w_st[SREM_W-1:0];
            r_root <= {r_root[LEVEL_W-2:0], w_sge};
            r_dq   <= {r_dq[SQ_W-3:0], 2'b00};
        end else begin
            r_srem <= r_srem;
        end
        if (i_cmd.out_load) begin
            r_out.sample_out   <= r_smp;
            r_out.levels_valid <= r_end;
            r_out.peak_level   <= r_end ? r_peak : '0;
            r_out.rms_level    <= r_end ? r_root : '0;
        end
    end

    assign o_out_word = r_out;

endmodule

`default_nettype wire

>>> src/capture_gain_gate_level_meter_top.sv
`default_nettype none

// Capture gain, noise gate and level meter. Each input word carries one signed
// mono sample (8-bit mode uses only its low byte, rescaled by 128 to Q.15) and
// a block-end flag. The sample is multiplied by the unsigned Q4.12 volume,
// truncated toward zero, gated to zero unless its magnitude is above the gate
// threshold, then narrowed to the configured width with saturation. Every
// sample feeds a block peak, a sum of squared magnitudes and a count; the word
// flagged last, or the one that fills a block of 4096 samples, also carries the
// peak and floor(sqrt(sum / count)) and clears the meter. One output word per
// input word, in order. An ordinary word is scaled, squared and accumulated;
// a block-end word then also goes through the serial divider (38 steps, one
// quotient bit a cycle) and the serial square root (19 steps), which share
// one shift register. Input is taken one word at a time; a finished word
// waits in the output register while the next input is accepted and worked on.
// Configuration is a plain write port (index 0: width mode, 1: volume,
// 2: gate); write it only while no word is in flight.

module capture_gain_gate_level_meter_top
    import cggl_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_word             i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_word                 o_out_word,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: one word at a time, output slot handshake
    cggl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // gain, gate, saturation, meter, divider and root
    cggl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_word  (o_out_word)
    );

    // levels are zero on words that do not end a block
    a_levels_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.levels_valid |->
            o_out_word.peak_level == '0 && o_out_word.rms_level == '0)
        else $error("levels set on a word that does not end a block");

    // never overwrite a word still waiting downstream
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !o_out_valid || i_out_ready)
        else $error("output register loaded while occupied");

    // an accepted word goes straight into scaling
    a_accept_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> w_cmd.scale)
        else $error("accepted word not scaled next cycle");

    // datapath commands never overlap
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command");

endmodule

`default_nettype wire
